FILE: sv/fmtmr_pkg.sv
package fmtmr_pkg;

    // command codes on s_tuser
    typedef enum logic [2:0] {
        CMD_ADDR      = 3'd0,
        CMD_ADDR_HI   = 3'd1,
        CMD_DATA      = 3'd2,
        CMD_STATUS    = 3'd3,
        CMD_STATUS_HI = 3'd4,
        CMD_TICK      = 3'd5
    } cmd_t;

    // result kinds on m_tuser
    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_FWD    = 1'b1
    } kind_t;

    // configuration register indexes
    localparam logic CFG_T1_TICK = 1'b0;
    localparam logic CFG_T2_TICK = 1'b1;

    localparam int TICK_W  = 10;
    localparam int COUNT_W = 8;
    localparam int REG_W   = 9;
    localparam int SPAN_W  = 19;   // (256 - count) * tick, at most 256 * 1023

    localparam logic [TICK_W-1:0] T1_TICK_RESET = 10'd80;
    localparam logic [TICK_W-1:0] T2_TICK_RESET = 10'd320;

    // chip register numbers
    localparam logic [REG_W-1:0] REG_T1_COUNT = 9'h002;
    localparam logic [REG_W-1:0] REG_T2_COUNT = 9'h003;
    localparam logic [REG_W-1:0] REG_TIMER_CTL = 9'h004;
    localparam logic [REG_W-1:0] REG_MODE     = 9'h105;
    localparam logic [REG_W-1:0] HIGH_BANK    = 9'h100;

    // timer control bits
    localparam int CTL_RESET_BIT = 7;
    localparam int CTL_MASK1_BIT = 6;
    localparam int CTL_MASK2_BIT = 5;
    localparam int CTL_ST1_BIT   = 0;
    localparam int CTL_ST2_BIT   = 1;

    // status bits
    localparam logic [7:0] STAT_ANY  = 8'h80;
    localparam logic [7:0] STAT_T1   = 8'h40;
    localparam logic [7:0] STAT_T2   = 8'h20;
    localparam logic [7:0] STAT_HIGH = 8'hff;

    // time to expiry for a count at a given tick period
    function automatic logic [SPAN_W-1:0] span_of(input logic [COUNT_W-1:0] count,
                                                  input logic [TICK_W-1:0] tick);
        logic [COUNT_W:0] left;
        left = 9'd256 - {1'b0, count};
        return SPAN_W'(left) * SPAN_W'(tick);
    endfunction

endpackage

FILE: sv/fm_chip_timer_register_port_top.sv
// Register front end of an FM sound chip with its two interval timers.
// Input stream (s_*): one transfer per bus access or time tick. s_tuser is the
// command (address write, high-bank address write, data write, status read,
// high-bank status read, tick); s_tdata carries the port byte and the elapsed
// microseconds of a tick.
// Result stream (m_*): status reads give a status byte (kind 0); data writes
// to any register other than the timer counts and timer control are passed on
// as register/data pairs (kind 1). Address writes, timer writes and ticks give
// no result.
// Config port: cfg_wr_en/cfg_index/cfg_wdata set the tick period of each timer
// in microseconds; write only while the stream is idle.
// Timing: a result passes through the input register, then the result
// register, and is held there until m_tready.
// Throughput: one transfer per cycle unless a held result stalls it; per item
// there are small timer-span multiplies and TIME_BITS-wide adds and compares.
// Reset (aresetn low, synchronous): clock, timers, address latch and mode flag
// clear, tick periods return to 80 and 320 us, both streams empty.
// Stall: a held result keeps the input register full, so s_tready drops only
// when the pending item itself must produce a result; items with no result
// keep flowing.
module fm_chip_timer_register_port_top
    import fmtmr_pkg::*;
#(
    parameter int TIME_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] value, [23:8] elapsed_us
    input  logic [2:0]  s_tuser,    // [2:0] command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] status_byte, [16:8] fwd_register,
                                    // [24:17] fwd_data, [25] four_op_mode, rest 0
    output logic        m_tuser,    // [0] kind

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);

    // configuration
    logic [TICK_W-1:0] tick1_reg, tick2_reg;

    // input stage
    logic               in_valid_reg, in_valid_next;
    logic [2:0]         cmd_reg;
    logic [7:0]         value_reg;
    logic [15:0]        elapsed_reg;
    logic [SPAN_W-1:0]  span_v1_reg, span_v2_reg;   // spans for the item's byte

    // chip state
    logic [REG_W-1:0]     addr_reg, addr_next;
    logic                 ext_mode_reg, ext_mode_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [COUNT_W-1:0]   t1_count_reg, t1_count_next, t2_count_reg, t2_count_next;
    logic                 t1_on_reg, t1_on_next, t2_on_reg, t2_on_next;
    logic [TIME_BITS-1:0] t1_dl_reg, t1_dl_next, t2_dl_reg, t2_dl_next;
    logic [SPAN_W-1:0]    span_c1_reg, span_c2_reg;   // spans for stored counts

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  status_reg, status_next;
    logic [8:0]  fwd_reg_reg, fwd_reg_next;
    logic [7:0]  fwd_data_reg, fwd_data_next;
    logic        four_op_reg, four_op_next;

    logic has_result, advance, in_xfer;
    logic [TIME_BITS-1:0] dl1_val, dl2_val, dl1_cnt, dl2_cnt;
    logic [7:0] stat_calc;

    assign in_xfer = s_tvalid && s_tready;

    // does the pending item produce a result
    always_comb begin
        has_result = 1'b0;
        unique case (cmd_reg)
            CMD_STATUS, CMD_STATUS_HI: has_result = 1'b1;
            CMD_DATA: has_result = (addr_reg != REG_T1_COUNT) &&
                                   (addr_reg != REG_T2_COUNT) &&
                                   (addr_reg != REG_TIMER_CTL);
            default: has_result = 1'b0;
        endcase
    end

    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign dl1_val = now_reg + TIME_BITS'(span_v1_reg);
    assign dl2_val = now_reg + TIME_BITS'(span_v2_reg);
    assign dl1_cnt = now_reg + TIME_BITS'(span_c1_reg);
    assign dl2_cnt = now_reg + TIME_BITS'(span_c2_reg);

    always_comb begin
        stat_calc = '0;
        if (t1_on_reg && (now_reg > t1_dl_reg)) stat_calc = stat_calc | STAT_ANY | STAT_T1;
        if (t2_on_reg && (now_reg > t2_dl_reg)) stat_calc = stat_calc | STAT_ANY | STAT_T2;
    end

    // item processing
    always_comb begin
        addr_next     = addr_reg;
        ext_mode_next = ext_mode_reg;
        now_next      = now_reg;
        t1_count_next = t1_count_reg;
        t2_count_next = t2_count_reg;
        t1_on_next    = t1_on_reg;
        t2_on_next    = t2_on_reg;
        t1_dl_next    = t1_dl_reg;
        t2_dl_next    = t2_dl_reg;
        kind_next     = kind_reg;
        status_next   = status_reg;
        fwd_reg_next  = fwd_reg_reg;
        fwd_data_next = fwd_data_reg;
        four_op_next  = four_op_reg;

        if (advance) begin
            unique case (cmd_reg)
                CMD_ADDR:    addr_next = {1'b0, value_reg};
                CMD_ADDR_HI: addr_next = HIGH_BANK | {1'b0, value_reg};
                CMD_TICK:    now_next  = now_reg + TIME_BITS'(elapsed_reg);
                CMD_STATUS_HI: begin
                    kind_next     = KIND_STATUS;
                    status_next   = STAT_HIGH;
                    fwd_reg_next  = '0;
                    fwd_data_next = '0;
                    four_op_next  = ext_mode_reg;
                end
                CMD_STATUS: begin
                    kind_next     = KIND_STATUS;
                    status_next   = stat_calc;
                    fwd_reg_next  = '0;
                    fwd_data_next = '0;
                    four_op_next  = ext_mode_reg;
                end
                CMD_DATA: begin
                    if (addr_reg == REG_T1_COUNT) begin
                        t1_count_next = value_reg;
                        if (t1_on_reg) t1_dl_next = dl1_val;
                    end else if (addr_reg == REG_T2_COUNT) begin
                        t2_count_next = value_reg;
                        if (t2_on_reg) t2_dl_next = dl2_val;
                    end else if (addr_reg == REG_TIMER_CTL) begin
                        if (value_reg[CTL_RESET_BIT]) begin
                            t1_on_next = 1'b0;
                            t2_on_next = 1'b0;
                        end else begin
                            if (!value_reg[CTL_MASK1_BIT]) begin
                                t1_on_next = value_reg[CTL_ST1_BIT];
                                if (value_reg[CTL_ST1_BIT]) t1_dl_next = dl1_cnt;
                            end
                            if (!value_reg[CTL_MASK2_BIT]) begin
                                t2_on_next = value_reg[CTL_ST2_BIT];
                                if (value_reg[CTL_ST2_BIT]) t2_dl_next = dl2_cnt;
                            end
                        end
                    end else begin
                        if (addr_reg == REG_MODE) ext_mode_next = value_reg[0];
                        kind_next     = KIND_FWD;
                        status_next   = '0;
                        fwd_reg_next  = addr_reg;
                        fwd_data_next = value_reg;
                        four_op_next  = (addr_reg == REG_MODE) ? value_reg[0] : ext_mode_reg;
                    end
                end
                default: ;  // unused codes are dropped
            endcase
        end
    end

    always_comb begin
        if (in_xfer)      in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;
        else              in_valid_next = in_valid_reg;

        if (advance && has_result) out_valid_next = 1'b1;
        else if (m_tready)         out_valid_next = 1'b0;
        else                       out_valid_next = out_valid_reg;
    end

    // control and chip state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick1_reg     <= T1_TICK_RESET;
            tick2_reg     <= T2_TICK_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            ext_mode_reg  <= 1'b0;
            now_reg       <= '0;
            t1_count_reg  <= '0;
            t2_count_reg  <= '0;
            t1_on_reg     <= 1'b0;
            t2_on_reg     <= 1'b0;
            t1_dl_reg     <= '0;
            t2_dl_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_T1_TICK: tick1_reg <= cfg_wdata;
                    CFG_T2_TICK: tick2_reg <= cfg_wdata;
                endcase
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            addr_reg      <= addr_next;
            ext_mode_reg  <= ext_mode_next;
            now_reg       <= now_next;
            t1_count_reg  <= t1_count_next;
            t2_count_reg  <= t2_count_next;
            t1_on_reg     <= t1_on_next;
            t2_on_reg     <= t2_on_next;
            t1_dl_reg     <= t1_dl_next;
            t2_dl_reg     <= t2_dl_next;
        end
    end

    // payload: input item, precomputed spans, result
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg     <= s_tuser;
            value_reg   <= s_tdata[7:0];
            elapsed_reg <= s_tdata[23:8];
            span_v1_reg <= span_of(s_tdata[7:0], tick1_reg);
            span_v2_reg <= span_of(s_tdata[7:0], tick2_reg);
        end
        // registered from the next counts, so it changes in the same cycle as the stored counts
        span_c1_reg  <= span_of(t1_count_next, tick1_reg);
        span_c2_reg  <= span_of(t2_count_next, tick2_reg);
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        fwd_reg_reg  <= fwd_reg_next;
        fwd_data_reg <= fwd_data_next;
        four_op_reg  <= four_op_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, four_op_reg, fwd_data_reg, fwd_reg_reg, status_reg};

endmodule
